>>> src/smc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the servo mode and calibration control.
// ----------------------------------------------------------------------------
package smc_pkg;

	localparam int NOW_W    = 32;
	localparam int POT_W    = 12;
	localparam int MODE_W   = 2;
	localparam int SERVO_W  = 4;
	localparam int ANGLE_W  = 15;
	localparam int LOCK_W   = 16;
	localparam int COUNT_W  = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_SERVOS_DEF = 16;
	localparam int SEL_LIMIT      = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 1'd1;

	localparam logic [LOCK_W-1:0]  LOCKOUT_RST = 16'd300;
	localparam logic [COUNT_W-1:0] COUNT_RST   = 5'd1;

	// mode codes on the result channel
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAL   = 2'd2;

	localparam logic [NOW_W-1:0] TOGGLE_MS = 32'd2000;

	// pot to angle mapping, floor((pot - 1000) * pi_q13 / 2000 + 1/2)
	localparam logic [POT_W-1:0] POT_LOW  = 12'd1000;
	localparam logic [POT_W-1:0] POT_HIGH = 12'd3000;
	localparam int               PROD_W   = 35;
	localparam int               ANG_SHIFT = 20;
	localparam logic [PROD_W-1:0] ANG_MUL = 35'd13493076;
	localparam logic [PROD_W-1:0] ANG_RND = 35'd524288;
	localparam logic [ANGLE_W-1:0] HALF_PI_Q13 = 15'd12868;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_SLEEP = 3'b010,
		ST_CAL   = 3'b100
	} mode_st_t;

	typedef struct packed {
		logic [NOW_W-1:0] now_ms;
		logic             square;
		logic             thin1;
		logic             thin2;
	} smc_btn_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SERVO_W-1:0] servo;
		logic               cal;
	} smc_ctrl_t;

endpackage

>>> src/smc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_if
// Valid/ready channels for update items and result items.
// ----------------------------------------------------------------------------
interface smc_in_if import smc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NOW_W-1:0]   now_ms;
	logic               square_pressed;
	logic               thin1_pressed;
	logic               thin2_pressed;
	logic [POT_W-1:0]   pot_reading;

	modport source (output valid, now_ms, square_pressed, thin1_pressed, thin2_pressed,
		pot_reading, input ready);
	modport sink (input valid, now_ms, square_pressed, thin1_pressed, thin2_pressed,
		pot_reading, output ready);
endinterface

interface smc_out_if import smc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [SERVO_W-1:0]        selected_servo;
	logic                      angle_valid;
	logic signed [ANGLE_W-1:0] target_angle;

	modport source (output valid, mode, selected_servo, angle_valid, target_angle,
		input ready);
	modport sink (input valid, mode, selected_servo, angle_valid, target_angle,
		output ready);
endinterface

>>> src/smc_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_angle
// Clamps the pot sample to 1000..3000 and maps it to -pi/2..pi/2 in Q2.13.
// ----------------------------------------------------------------------------
module smc_angle import smc_pkg::*; (
	input  logic [POT_W-1:0]          pot,
	output logic signed [ANGLE_W-1:0] angle
);

	logic [POT_W-1:0]   pot_c;
	logic [10:0]        span;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  sum;
	logic [ANGLE_W-1:0] scaled;

	always_comb begin
		if (pot < POT_LOW) begin
			pot_c = POT_LOW;
		end else if (pot > POT_HIGH) begin
			pot_c = POT_HIGH;
		end else begin
			pot_c = pot;
		end
	end

	assign span   = 11'(pot_c - POT_LOW);
	// reciprocal multiply, exact for the clamped span
	assign prod   = PROD_W'(span) * ANG_MUL;
	assign sum    = prod + ANG_RND;
	assign scaled = sum[ANG_SHIFT +: ANGLE_W];
	assign angle  = $signed(scaled - HALF_PI_Q13);

endmodule

>>> src/smc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_ctrl
// Mode, toggle time stamp, lockout and servo selection state.
// ----------------------------------------------------------------------------
module smc_ctrl import smc_pkg::*; #(
	parameter int MAX_SERVOS = MAX_SERVOS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  smc_btn_t           btn,
	input  logic [LOCK_W-1:0]  lockout_ms,
	input  logic [COUNT_W-1:0] servo_count,
	output smc_ctrl_t          res
);

	localparam int NMAX = (MAX_SERVOS < SEL_LIMIT) ? MAX_SERVOS : SEL_LIMIT;
	localparam logic [COUNT_W-1:0] NMAX_L = COUNT_W'(NMAX);

	mode_st_t           mode_q;
	logic [NOW_W-1:0]   toggle_time_q;
	logic               lock_q;
	logic [NOW_W-1:0]   lock_time_q;
	logic [SERVO_W-1:0] servo_q;

	mode_st_t           mode_1;
	mode_st_t           mode_2;
	logic               tog;
	logic               both;
	logic               enter;
	logic               leave;
	logic               lock_1;
	logic               lock_2;
	logic               lock_n;
	logic [NOW_W-1:0]   lock_time_n;
	logic               sel;
	logic [COUNT_W-1:0] cnt;
	logic [SERVO_W-1:0] last;
	logic [COUNT_W-1:0] up;
	logic [SERVO_W-1:0] servo_n;
	logic [MODE_W-1:0]  mode_code;

	assign both = btn.thin1 && btn.thin2;
	assign tog  = btn.square && (mode_q != ST_CAL) && ((btn.now_ms - toggle_time_q) > TOGGLE_MS);

	always_comb begin
		mode_1 = mode_q;
		if (tog) begin
			case (mode_q)
				ST_RUN:   mode_1 = ST_SLEEP;
				ST_SLEEP: mode_1 = ST_RUN;
				default:  mode_1 = mode_q;
			endcase
		end
	end

	assign enter  = (mode_1 == ST_RUN) && both && !lock_q;
	assign leave  = (mode_1 == ST_CAL) && both && !lock_q;
	assign mode_2 = enter ? ST_CAL : (leave ? ST_RUN : mode_1);
	assign lock_1 = lock_q || enter || leave;

	// effective servo count, 1..min(MAX_SERVOS, 16)
	always_comb begin
		if (servo_count == '0) begin
			cnt = COUNT_W'(1);
		end else if (servo_count > NMAX_L) begin
			cnt = NMAX_L;
		end else begin
			cnt = servo_count;
		end
	end

	assign last = SERVO_W'(cnt - COUNT_W'(1));
	assign up   = COUNT_W'(servo_q) + COUNT_W'(1);
	assign sel  = (mode_2 == ST_CAL) && !lock_1;

	always_comb begin
		servo_n     = servo_q;
		lock_2      = lock_1;
		lock_time_n = (enter || leave) ? btn.now_ms : lock_time_q;
		if (sel) begin
			if (btn.square || btn.thin1 || btn.thin2) begin
				lock_2      = 1'b1;
				lock_time_n = btn.now_ms;
			end
			if (btn.thin1) begin
				servo_n = (up > COUNT_W'(last)) ? '0 : SERVO_W'(up);
			end else if (btn.thin2) begin
				servo_n = (servo_q == '0) ? last : servo_q - SERVO_W'(1);
			end
		end
	end

	// lockout expiry
	assign lock_n = lock_2 && !((btn.now_ms - lock_time_n) > NOW_W'(lockout_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ST_SLEEP;
			toggle_time_q <= '0;
			lock_q        <= 1'b0;
			lock_time_q   <= '0;
			servo_q       <= '0;
		end else if (step) begin
			mode_q      <= mode_2;
			lock_q      <= lock_n;
			lock_time_q <= lock_time_n;
			servo_q     <= servo_n;
			if (tog) begin
				toggle_time_q <= btn.now_ms;
			end
		end
	end

	always_comb begin
		case (mode_2)
			ST_RUN:   mode_code = MODE_RUN;
			ST_SLEEP: mode_code = MODE_SLEEP;
			ST_CAL:   mode_code = MODE_CAL;
			default:  mode_code = MODE_SLEEP;
		endcase
	end

	assign res.mode  = mode_code;
	assign res.servo = servo_n;
	assign res.cal   = (mode_2 == ST_CAL);

endmodule

>>> src/servo_mode_and_calibration_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_mode_and_calibration_control
// Run/sleep/calibrate mode control with servo selection and pot angle mapping.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                              | transfer
//  in_ch   | in  | now_ms, square/thin1/thin2_pressed, pot_reading      | valid & ready
//  out_ch  | out | mode, selected_servo, angle_valid, target_angle      | valid & ready
//  cfg     | in  | cfg_index, cfg_wdata                                 | cfg_we
//
//  input transfer to result valid: through the input register, then the result register
//  one item per cycle sustained while out_ch.ready is high; the mode and lockout
//  state update as the item leaves the input register for the result register
//  a stalled result register holds one item and the input register one more
//  reset: sleeping, no lockout, servo 0, lockout_ms 300, servo_count 1
// ----------------------------------------------------------------------------
module servo_mode_and_calibration_control import smc_pkg::*; #(
	parameter int MAX_SERVOS = MAX_SERVOS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smc_in_if.sink                in_ch,
	smc_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [LOCK_W-1:0]  lockout_q;
	logic [COUNT_W-1:0] count_q;

	logic               v_s1;
	smc_btn_t           btn_s1;
	logic [POT_W-1:0]   pot_s1;

	logic                      v_s2;
	logic [MODE_W-1:0]         mode_s2;
	logic [SERVO_W-1:0]        servo_s2;
	logic                      aval_s2;
	logic signed [ANGLE_W-1:0] angle_s2;

	logic                      adv;
	logic                      take;
	smc_ctrl_t                 ctrl;
	logic signed [ANGLE_W-1:0] angle;

	assign adv          = v_s1 && (!v_s2 || out_ch.ready);
	assign in_ch.ready  = !v_s1 || adv;
	assign take         = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RST;
			count_q   <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCKOUT_MS:  lockout_q <= cfg_wdata[LOCK_W-1:0];
				REG_SERVO_COUNT: count_q   <= cfg_wdata[COUNT_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			btn_s1.now_ms <= in_ch.now_ms;
			btn_s1.square <= in_ch.square_pressed;
			btn_s1.thin1  <= in_ch.thin1_pressed;
			btn_s1.thin2  <= in_ch.thin2_pressed;
			pot_s1        <= in_ch.pot_reading;
		end
	end

	smc_ctrl #(
		.MAX_SERVOS (MAX_SERVOS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.btn         (btn_s1),
		.lockout_ms  (lockout_q),
		.servo_count (count_q),
		.res         (ctrl)
	);

	smc_angle u_angle (
		.pot   (pot_s1),
		.angle (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= ctrl.mode;
			servo_s2 <= ctrl.servo;
			aval_s2  <= ctrl.cal;
			angle_s2 <= ctrl.cal ? angle : '0;
		end
	end

	assign out_ch.valid          = v_s2;
	assign out_ch.mode           = mode_s2;
	assign out_ch.selected_servo = servo_s2;
	assign out_ch.angle_valid    = aval_s2;
	assign out_ch.target_angle   = angle_s2;

	a_aval_mode: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (aval_s2 == (mode_s2 == MODE_CAL)))
		else $error("angle_valid does not follow calibrating mode");

	a_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !aval_s2) |-> (angle_s2 == '0))
		else $error("angle not zero outside calibration");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (angle_s2 <= $signed(HALF_PI_Q13) && angle_s2 >= -$signed(HALF_PI_Q13)))
		else $error("angle outside -pi/2..pi/2");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (mode_s2 == MODE_RUN || mode_s2 == MODE_SLEEP || mode_s2 == MODE_CAL))
		else $error("illegal mode code in result");

endmodule
